// ===== rtl/core/llcf_pkg.sv =====
// shared constants, types and widths for the lat/lon to cartesian and flat block
package llcf_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int TRIG_ITERATIONS = 18;
  localparam int ONE             = 2 ** FRAC_BITS;

  // cordic datapath width: q60 values of magnitude below two
  localparam int CW  = 62;
  localparam int SHW = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;

  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = 3;
  localparam int NSTAGES      = FRONT_STAGES + TRIG_ITERATIONS + BACK_STAGES;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef logic signed [CW-1:0] cw_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
    cw_t z;
  } rot_t;

  typedef struct packed {
    logic sneg;
    logic cneg;
  } quad_t;

  // data riding alongside the rotators
  typedef struct packed {
    quad_t       lat_q;
    quad_t       lon_q;
    logic        fx_neg;
    logic [17:0] fx_q;
    logic        fy_neg;
    logic [15:0] fy_q;
    logic        last;
  } side_t;

  typedef logic signed [23:0] lat_t;
  typedef logic signed [25:0] lon_t;
  typedef logic signed [17:0] sph_t;
  typedef logic signed [17:0] flx_t;
  typedef logic signed [16:0] fly_t;

endpackage

// ===== rtl/core/llcf_if.sv =====
// input and result channel interfaces
interface llcf_in_if import llcf_pkg::*; ();
  logic valid;
  logic ready;
  lat_t lat_deg;
  lon_t lon_deg;
  logic last_point;

  modport source (output valid, lat_deg, lon_deg, last_point, input ready);
  modport sink (input valid, lat_deg, lon_deg, last_point, output ready);
endinterface

interface llcf_out_if import llcf_pkg::*; ();
  logic valid;
  logic ready;
  sph_t sphere_x;
  sph_t sphere_y;
  sph_t sphere_z;
  flx_t flat_x;
  fly_t flat_y;
  logic last_out;

  modport source (output valid, sphere_x, sphere_y, sphere_z, flat_x, flat_y, last_out,
                  input ready);
  modport sink (input valid, sphere_x, sphere_y, sphere_z, flat_x, flat_y, last_out,
                output ready);
endinterface

// ===== rtl/core/latlon_to_cartesian_and_flat.sv =====
// top level: grid point latitude/longitude to unit sphere and flat map coordinates
//
// usage
//   in_ch  takes one grid point per item: lat_deg, lon_deg (degrees, 16 fraction
//          bits) and last_point. an item is taken when valid and ready are high.
//   out_ch gives one result per item: sphere_x/y/z, flat_x, flat_y (16 fraction
//          bits; all but flat_y clamped to +-1) and last_out, in input order.
//   an item passes from input acceptance to out valid through 3 front stages
//          (fold, radian multiply, radian sum), 18 cordic cells, 3 back stages
//          (round, multiply, round and clamp; the last is the output register).
//   one item per cycle unless out_ch stalls; the 18-cell cordic row sets the depth.
//   each stage has its own valid bit and loads whenever it is empty or the
//          stage after it moves, so bubbles close up while out_ch stalls and
//          new items are still taken until every stage holds an item.
//   ready depends combinationally on out_ch.ready through the stage valids.
//   synchronous active-low reset clears all valid bits; the datapath keeps
//          its contents and nothing is presented until new items arrive.
module latlon_to_cartesian_and_flat import llcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  llcf_in_if.sink           in_ch,
  llcf_out_if.source        out_ch
);

  // one valid bit per pipeline stage, plus the per-stage load enables
  logic [NSTAGES-1:0] v_r, v_nxt;
  logic [NSTAGES-1:0] en;

  rot_t  f_lat, f_lon, c_lat, c_lon;
  side_t f_side, c_side;

  // a stage may load unless it and every stage after it are full and
  // the receiver holds off
  for (genvar k = 0; k < NSTAGES; k++) begin : g_en
    assign en[k] = out_ch.ready | ~(&v_r[NSTAGES-1:k]);
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_ch.valid : v_r[0];
    for (int k = 1; k < NSTAGES; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = v_r[NSTAGES-1];

  // angle folding, radian scaling and flat map division
  llcf_front u_front (
    .clk        (clk),
    .en         (en[FRONT_STAGES-1:0]),
    .lat_deg    (in_ch.lat_deg),
    .lon_deg    (in_ch.lon_deg),
    .last_point (in_ch.last_point),
    .lat_rot    (f_lat),
    .lon_rot    (f_lon),
    .side       (f_side)
  );

  // cordic rotation row for both angles
  llcf_chain u_chain (
    .clk    (clk),
    .en     (en[FRONT_STAGES +: TRIG_ITERATIONS]),
    .lat_i  (f_lat),
    .lon_i  (f_lon),
    .side_i (f_side),
    .lat_o  (c_lat),
    .lon_o  (c_lon),
    .side_o (c_side)
  );

  // sin/cos rounding, products and the output register
  llcf_back u_back (
    .clk      (clk),
    .en       (en[NSTAGES-1 -: BACK_STAGES]),
    .lat_rot  (c_lat),
    .lon_rot  (c_lon),
    .side     (c_side),
    .sphere_x (out_ch.sphere_x),
    .sphere_y (out_ch.sphere_y),
    .sphere_z (out_ch.sphere_z),
    .flat_x   (out_ch.flat_x),
    .flat_y   (out_ch.flat_y),
    .last_out (out_ch.last_out)
  );

`ifndef NO_ASSERTIONS
  // input is refused only when every stage holds an item
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input refused with a free stage");

  // an accepted item occupies the first stage on the next cycle
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[0])
    else $error("accepted item lost at first stage");

  // sphere results stay within plus or minus one
  a_sphere_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.sphere_x <= ONE && out_ch.sphere_x >= -ONE &&
                      out_ch.sphere_z <= ONE && out_ch.sphere_z >= -ONE &&
                      out_ch.sphere_y <= ONE && out_ch.sphere_y >= -ONE))
    else $error("sphere result out of range");

  // flat x result stays within plus or minus one
  a_flat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.flat_x <= ONE && out_ch.flat_x >= -ONE))
    else $error("flat x result out of range");
`endif

endmodule

// ===== rtl/core/llcf_front.sv =====
// front stages: angle folding, degree to radian scaling, flat map division
module llcf_front import llcf_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] en,
  input  lat_t                    lat_deg,
  input  lon_t                    lon_deg,
  input  logic                    last_point,
  output rot_t                    lat_rot,
  output rot_t                    lon_rot,
  output side_t                   side
);

  localparam logic signed [26:0] D90  = 27'(90 * ONE);
  localparam logic signed [26:0] D180 = 27'(180 * ONE);
  localparam logic signed [26:0] D270 = 27'(270 * ONE);
  localparam logic signed [26:0] D360 = 27'(360 * ONE);
  localparam logic signed [26:0] D720 = 27'(720 * ONE);

  localparam logic [63:0] RAD_Q60 = PI_Q60 / 64'd180;
  localparam logic [22:0] RAD_HI  = RAD_Q60[54:32];
  localparam logic [31:0] RAD_LO  = RAD_Q60[31:0];
  localparam cw_t         GAIN_Q60 = 62'sd700114967507362900;

  // floor(b / 45) = (b * RECIP45) >> 31 for all b below 2^24
  localparam logic [25:0] RECIP45 = 26'(((64'd1 << 31) + 64'd44) / 64'd45);

  typedef struct packed {
    quad_t       q;
    logic [22:0] ang;
  } fold_t;

  // map [0, 360) degrees onto [0, 90] with sign flips for sin and cos
  function automatic fold_t fold(input logic signed [26:0] d);
    fold_t f;
    f = '0;
    priority if (d <= D90) begin
      f.ang = d[22:0];
    end else if (d < D180) begin
      f.ang    = 23'(D180 - d);
      f.q.cneg = 1'b1;
    end else if (d <= D270) begin
      f.ang    = 23'(d - D180);
      f.q.sneg = 1'b1;
      f.q.cneg = 1'b1;
    end else begin
      f.ang    = 23'(D360 - d);
      f.q.sneg = 1'b1;
    end
    return f;
  endfunction

  logic signed [26:0] lat_s, lon_s, lat_red, lon_red;
  lon_t               fx_num;

  fold_t              fl_lat_r, fl_lon_r;
  lon_t               fxn_r;
  lat_t               fyn_r;
  logic               last0_r, last1_r;

  logic [45:0]        phi_lat_r, phi_lon_r;
  logic [54:0]        plo_lat_r, plo_lon_r;
  quad_t              q_lat_r, q_lon_r;
  logic [23:0]        bx_r;
  logic [21:0]        by_r;
  logic               fxneg_r, fyneg_r;
  logic signed [26:0] ax;
  logic signed [24:0] ay;

  logic [49:0]        qx_prod;
  logic [47:0]        qy_prod;
  cw_t                z_lat_r, z_lon_r;
  side_t              side_r;

  always_comb begin
    lat_s   = 27'(lat_deg);
    lon_s   = 27'(lon_deg);
    lat_red = (lat_s < 0) ? lat_s + D360 : lat_s;
    priority if (lon_s < -D360) begin
      lon_red = lon_s + D720;
    end else if (lon_s < 0) begin
      lon_red = lon_s + D360;
    end else if (lon_s >= D360) begin
      lon_red = lon_s - D360;
    end else begin
      lon_red = lon_s;
    end
    fx_num = (lon_deg > lon_t'(180 * ONE)) ? lon_deg - lon_t'(360 * ONE) : lon_deg;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fl_lat_r <= fold(lat_red);
      fl_lon_r <= fold(lon_red);
      fxn_r    <= fx_num;
      fyn_r    <= lat_deg;
      last0_r  <= last_point;
    end
  end

  // magnitude plus half the divisor, then divide by four ahead of the /45
  always_comb begin
    ax = fxn_r[25] ? (27'sd90 - 27'(fxn_r)) : (27'(fxn_r) + 27'sd90);
    ay = fyn_r[23] ? (25'sd90 - 25'(fyn_r)) : (25'(fyn_r) + 25'sd90);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      phi_lat_r <= 46'(fl_lat_r.ang) * 46'(RAD_HI);
      plo_lat_r <= 55'(fl_lat_r.ang) * 55'(RAD_LO);
      phi_lon_r <= 46'(fl_lon_r.ang) * 46'(RAD_HI);
      plo_lon_r <= 55'(fl_lon_r.ang) * 55'(RAD_LO);
      q_lat_r   <= fl_lat_r.q;
      q_lon_r   <= fl_lon_r.q;
      bx_r      <= ax[25:2];
      by_r      <= ay[23:2];
      fxneg_r   <= fxn_r[25];
      fyneg_r   <= fyn_r[23];
      last1_r   <= last0_r;
    end
  end

  always_comb begin
    qx_prod = 50'(bx_r) * 50'(RECIP45);
    qy_prod = 48'(by_r) * 48'(RECIP45);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      z_lat_r       <= (CW'(phi_lat_r) << FRAC_BITS) + CW'(plo_lat_r >> FRAC_BITS);
      z_lon_r       <= (CW'(phi_lon_r) << FRAC_BITS) + CW'(plo_lon_r >> FRAC_BITS);
      side_r.lat_q  <= q_lat_r;
      side_r.lon_q  <= q_lon_r;
      side_r.fx_neg <= fxneg_r;
      side_r.fx_q   <= qx_prod[48:31];
      side_r.fy_neg <= fyneg_r;
      side_r.fy_q   <= qy_prod[46:31];
      side_r.last   <= last1_r;
    end
  end

  assign lat_rot = '{x: GAIN_Q60, y: '0, z: z_lat_r};
  assign lon_rot = '{x: GAIN_Q60, y: '0, z: z_lon_r};
  assign side    = side_r;

endmodule

// ===== rtl/core/llcf_cell.sv =====
// one cordic micro-rotation cell for both angles, with sideband hand-over
module llcf_cell import llcf_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [SHW-1:0] shift,
  input  cw_t            atan,
  input  rot_t           lat_i,
  input  rot_t           lon_i,
  input  side_t          side_i,
  output rot_t           lat_o,
  output rot_t           lon_o,
  output side_t          side_o
);

  function automatic rot_t rotate(input rot_t r, input logic [SHW-1:0] sh, input cw_t a);
    cw_t  dx;
    cw_t  dy;
    rot_t n;
    dx = r.y >>> sh;
    dy = r.x >>> sh;
    if (r.z >= 0) begin
      n.x = r.x - dx;
      n.y = r.y + dy;
      n.z = r.z - a;
    end else begin
      n.x = r.x + dx;
      n.y = r.y - dy;
      n.z = r.z + a;
    end
    return n;
  endfunction

  rot_t  lat_r, lon_r;
  side_t side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lat_r  <= rotate(lat_i, shift, atan);
      lon_r  <= rotate(lon_i, shift, atan);
      side_r <= side_i;
    end
  end

  assign lat_o  = lat_r;
  assign lon_o  = lon_r;
  assign side_o = side_r;

endmodule

// ===== rtl/core/llcf_chain.sv =====
// row of cordic cells, one micro-rotation per cell
module llcf_chain import llcf_pkg::*; (
  input  logic                       clk,
  input  logic [TRIG_ITERATIONS-1:0] en,
  input  rot_t                       lat_i,
  input  rot_t                       lon_i,
  input  side_t                      side_i,
  output rot_t                       lat_o,
  output rot_t                       lon_o,
  output side_t                      side_o
);

  // unsigned quotient by shift and subtract, evaluated at elaboration only
  function automatic longint quot(input longint num, input longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (longint'(1) <<< b);
      end
    end
    return q;
  endfunction

  // arctangent of 2^-idx at q60: pi/4 for idx 0, else the truncated power series
  function automatic cw_t atan_entry(input int idx);
    longint sum;
    longint term;
    int     n;
    logic   neg;
    sum = 0;
    neg = 1'b0;
    if (idx == 0) begin
      sum = longint'(PI_Q60 >> 2);
    end else begin
      for (n = 1; idx * n <= 60; n = n + 2) begin
        term = quot(longint'(64'd1 << (60 - idx * n)), longint'(n));
        sum  = neg ? sum - term : sum + term;
        neg  = ~neg;
      end
    end
    return CW'(sum);
  endfunction

  rot_t  lat_w  [TRIG_ITERATIONS+1];
  rot_t  lon_w  [TRIG_ITERATIONS+1];
  side_t side_w [TRIG_ITERATIONS+1];

  assign lat_w[0]  = lat_i;
  assign lon_w[0]  = lon_i;
  assign side_w[0] = side_i;

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cell
    localparam cw_t ATAN_I = atan_entry(i);

    llcf_cell u_cell (
      .clk    (clk),
      .en     (en[i]),
      .shift  (SHW'(i)),
      .atan   (ATAN_I),
      .lat_i  (lat_w[i]),
      .lon_i  (lon_w[i]),
      .side_i (side_w[i]),
      .lat_o  (lat_w[i+1]),
      .lon_o  (lon_w[i+1]),
      .side_o (side_w[i+1])
    );
  end

  assign lat_o  = lat_w[TRIG_ITERATIONS];
  assign lon_o  = lon_w[TRIG_ITERATIONS];
  assign side_o = side_w[TRIG_ITERATIONS];

endmodule

// ===== rtl/core/llcf_back.sv =====
// back stages: sin/cos rounding, products, final rounding and clamping
module llcf_back import llcf_pkg::*; (
  input  logic                   clk,
  input  logic [BACK_STAGES-1:0] en,
  input  rot_t                   lat_rot,
  input  rot_t                   lon_rot,
  input  side_t                  side,
  output sph_t                   sphere_x,
  output sph_t                   sphere_y,
  output sph_t                   sphere_z,
  output flx_t                   flat_x,
  output fly_t                   flat_y,
  output logic                   last_out
);

  localparam int SY_SH = 30 - FRAC_BITS;
  localparam int SP_SH = 60 - FRAC_BITS;

  localparam logic signed [CW:0]   HALF30 = (CW+1)'(1) << 29;
  localparam logic signed [33:0]   HALF_Y = 34'sd1 << (SY_SH - 1);
  localparam logic signed [64:0]   HALF_P = 65'sd1 << (SP_SH - 1);
  localparam logic signed [20:0]   ONE_S  = 21'(ONE);

  typedef logic signed [31:0] tr_t;
  typedef logic signed [63:0] pr_t;

  // optional negate, then round half up from 60 to 30 fraction bits
  function automatic tr_t round30(input cw_t v, input logic neg);
    logic signed [CW:0] ve;
    logic signed [CW:0] t;
    ve = (CW+1)'(v);
    t  = neg ? (HALF30 - ve) : (ve + HALF30);
    return tr_t'(t >>> 30);
  endfunction

  function automatic sph_t clamp_one(input logic signed [20:0] v);
    sph_t r;
    priority if (v > ONE_S) begin
      r = sph_t'(ONE_S);
    end else if (v < -ONE_S) begin
      r = sph_t'(-ONE_S);
    end else begin
      r = sph_t'(v);
    end
    return r;
  endfunction

  tr_t         slat_r, clat_r, slon_r, clon_r;
  flx_t        fx0_r, fx1_r, fx2_r;
  fly_t        fy0_r, fy1_r, fy2_r;
  logic        last0_r, last1_r, last2_r;
  logic [17:0] fx_clamp;

  pr_t         px_r, pz_r;
  sph_t        sy_r, sy2_r;
  sph_t        sx_r, sz_r;

  assign fx_clamp = (side.fx_q > 18'(ONE)) ? 18'(ONE) : side.fx_q;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      slat_r  <= round30(lat_rot.y, side.lat_q.sneg);
      clat_r  <= round30(lat_rot.x, side.lat_q.cneg);
      slon_r  <= round30(lon_rot.y, side.lon_q.sneg);
      clon_r  <= round30(lon_rot.x, side.lon_q.cneg);
      fx0_r   <= side.fx_neg ? -flx_t'(fx_clamp) : flx_t'(fx_clamp);
      fy0_r   <= side.fy_neg ? -fly_t'(side.fy_q) : fly_t'(side.fy_q);
      last0_r <= side.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      px_r    <= pr_t'(clat_r) * pr_t'(slon_r);
      pz_r    <= pr_t'(clat_r) * pr_t'(clon_r);
      sy_r    <= clamp_one(21'((34'(slat_r) + HALF_Y) >>> SY_SH));
      fx1_r   <= fx0_r;
      fy1_r   <= fy0_r;
      last1_r <= last0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sx_r    <= clamp_one(21'((65'(px_r) + HALF_P) >>> SP_SH));
      sz_r    <= clamp_one(21'((65'(pz_r) + HALF_P) >>> SP_SH));
      sy2_r   <= sy_r;
      fx2_r   <= fx1_r;
      fy2_r   <= fy1_r;
      last2_r <= last1_r;
    end
  end

  assign sphere_x = sx_r;
  assign sphere_y = sy2_r;
  assign sphere_z = sz_r;
  assign flat_x   = fx2_r;
  assign flat_y   = fy2_r;
  assign last_out = last2_r;

endmodule
